[rtl/core/assert_macros.svh]
// assert_macros.svh: assertion macros used by palette_duplicate_color_nudger
// expects clk_i and the active-low rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[rtl/core/pdcn_pkg.sv]
// pdcn_pkg: widths, constants, sequencer states and shared types of the
// palette duplicate color nudger; no dependencies
package pdcn_pkg;

  localparam int unsigned RGB_W       = 24;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned CH_N        = 3;
  localparam int unsigned NUDGE_W     = 8;
  localparam int unsigned IDX_OUT_W   = 4;
  localparam int unsigned ENTRIES_DEF = 16;

  localparam logic [NUDGE_W-1:0] NUDGE_INIT = NUDGE_W'(1);

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_REF_LAT,
    ST_CMP,
    ST_EMIT
  } pdcn_state_e;

  // result of the shared compare and nudge unit
  typedef struct packed {
    logic             hit;
    logic [RGB_W-1:0] rgb;
  } pdcn_nudge_res_t;

endpackage

[rtl/core/pdcn_ram.sv]
// pdcn_ram: generic single-write, single-read RAM with registered read data
// no package dependency
module pdcn_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/pdcn_nudge.sv]
// pdcn_nudge: shared unit that compares a candidate entry with the reference
// color and forms the nudged color; uses pdcn_pkg
module pdcn_nudge (
  input  logic [pdcn_pkg::RGB_W-1:0]   ref_rgb_i,
  input  logic [pdcn_pkg::RGB_W-1:0]   cand_rgb_i,
  input  logic [pdcn_pkg::NUDGE_W-1:0] amount_i,
  output pdcn_pkg::pdcn_nudge_res_t    res_o
);
  import pdcn_pkg::*;

  // per channel: step up, or step down when the step up would carry out
  always_comb begin
    logic [CH_W:0]   sum;
    logic [CH_W-1:0] ch;
    res_o.hit = (cand_rgb_i == ref_rgb_i);
    res_o.rgb = cand_rgb_i;
    for (int c = 0; c < CH_N; c++) begin
      ch  = cand_rgb_i[c*CH_W +: CH_W];
      sum = {1'b0, ch} + {1'b0, amount_i};
      if (sum[CH_W]) begin
        res_o.rgb[c*CH_W +: CH_W] = ch - amount_i;
      end else begin
        res_o.rgb[c*CH_W +: CH_W] = sum[CH_W-1:0];
      end
    end
  end

endmodule

[rtl/core/palette_duplicate_color_nudger.sv]
// palette_duplicate_color_nudger: top level with sequencer, palette RAM and
// shared compare/nudge unit; uses pdcn_pkg, pdcn_ram, pdcn_nudge, assert_macros.svh
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+----------------------------
//  input   | color_rgb_i                              | in_valid_i / in_stall_o
//  output  | out_rgb_o, entry_index_o, last_entry_o   | out_valid_o / out_stall_i
//
//  loading takes one cycle per entry; the input is stalled outside loading
//  the pair walk runs through the one RAM read port and the compare/nudge unit: a start
//  state, then per outer entry a reference read and one compare per later entry
//  emitting gives one entry per cycle while out_stall_i is low
//  after reset the block is loading, palette contents undefined until written
`include "assert_macros.svh"

module palette_duplicate_color_nudger #(
  parameter int unsigned ENTRIES = pdcn_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pdcn_pkg::RGB_W-1:0]     color_rgb_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pdcn_pkg::RGB_W-1:0]     out_rgb_o,
  output logic [pdcn_pkg::IDX_OUT_W-1:0] entry_index_o,
  output logic                           last_entry_o
);
  import pdcn_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST   = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_F = IDX_W'(ENTRIES - 2);

  pdcn_state_e        state_q, state_d;
  logic [IDX_W-1:0]   load_cnt_q;
  logic [IDX_W-1:0]   f_q;
  logic [IDX_W-1:0]   g_q;
  logic [IDX_W-1:0]   e_q;
  logic [RGB_W-1:0]   ref_q;
  logic [NUDGE_W-1:0] nudge_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [RGB_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [RGB_W-1:0]   ram_rdata;

  pdcn_nudge_res_t    nres;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // palette store
  pdcn_ram #(
    .WIDTH (RGB_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared compare and nudge unit
  pdcn_nudge u_nudge (
    .ref_rgb_i  (ref_q),
    .cand_rgb_i (ram_rdata),
    .amount_i   (nudge_q),
    .res_o      (nres)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && load_cnt_q == LAST) begin
          state_d = ST_START;
        end
      end
      ST_START:   state_d = ST_REF_LAT;
      ST_REF_LAT: state_d = ST_CMP;
      ST_CMP: begin
        if (g_q == LAST) begin
          state_d = (f_q == LAST_F) ? ST_EMIT : ST_REF_LAT;
        end
      end
      ST_EMIT: begin
        if (out_acc && e_q == LAST) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // RAM port control and handshake outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_cnt_q;
    ram_wdata = color_rgb_i;
    ram_re    = 1'b0;
    ram_raddr = f_q;
    case (state_q)
      ST_LOAD: begin
        ram_we = in_valid_i;
      end
      ST_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_REF_LAT: begin
        ram_re    = 1'b1;
        ram_raddr = f_q + IDX_W'(1);
      end
      ST_CMP: begin
        ram_we    = nres.hit;
        ram_waddr = g_q;
        ram_wdata = nres.rgb;
        ram_re    = 1'b1;
        if (g_q != LAST) begin
          ram_raddr = g_q + IDX_W'(1);
        end else if (f_q != LAST_F) begin
          ram_raddr = f_q + IDX_W'(1);
        end else begin
          ram_raddr = '0;
        end
      end
      ST_EMIT: begin
        ram_re    = !out_stall_i && (e_q != LAST);
        ram_raddr = e_q + IDX_W'(1);
      end
      default: ;
    endcase
  end

  assign in_stall_o    = (state_q != ST_LOAD);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign out_rgb_o     = ram_rdata;
  assign entry_index_o = IDX_OUT_W'(e_q);
  assign last_entry_o  = (e_q == LAST);

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      f_q        <= '0;
      g_q        <= '0;
      e_q        <= '0;
      nudge_q    <= NUDGE_INIT;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (load_cnt_q == LAST) begin
              load_cnt_q <= '0;
              nudge_q    <= NUDGE_INIT;
              f_q        <= '0;
            end else begin
              load_cnt_q <= load_cnt_q + IDX_W'(1);
            end
          end
        end
        ST_REF_LAT: begin
          g_q <= f_q + IDX_W'(1);
        end
        ST_CMP: begin
          if (nres.hit) begin
            nudge_q <= nudge_q + NUDGE_W'(1);
          end
          if (g_q != LAST) begin
            g_q <= g_q + IDX_W'(1);
          end else if (f_q != LAST_F) begin
            f_q <= f_q + IDX_W'(1);
          end else begin
            e_q <= '0;
          end
        end
        ST_EMIT: begin
          if (out_acc && e_q != LAST) begin
            e_q <= e_q + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // reference color of the current outer pass
  always_ff @(posedge clk_i) begin
    if (state_q == ST_REF_LAT) begin
      ref_q <= ram_rdata;
    end
  end

  // checks
  `ASSERT_NEVER(a_no_load_while_emit, out_valid_o && !in_stall_o,
                "input accepted while results are pending")
  `ASSERT_CLK(a_build_after_load, in_acc && load_cnt_q == LAST |=> state_q == ST_START,
              "pair walk did not start after the final entry")
  `ASSERT_CLK(a_nudge_restart, state_q == ST_START |-> nudge_q == NUDGE_INIT,
              "nudge amount not restarted for a new walk")
  `ASSERT_CLK(a_pair_order, state_q == ST_CMP |-> g_q > f_q,
              "inner index not above outer index")
  `ASSERT_CLK(a_reload_after_last, out_acc && last_entry_o |=> !in_stall_o,
              "block not ready after the final entry was taken")

endmodule
